FILE: hw/rtl/gbs_pkg.sv
// Shared constants and types for greedy box suppression.
package gbs_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int SCORE_W        = 16;
  localparam int THR_W          = 16;
  localparam int KEPT_W         = 6;
  localparam int IN_DATA_W      = 80;
  localparam int OUT_DATA_W     = 8;
  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic       valid;
    logic [5:0] idx;
    logic       supp;
  } gbs_res_t;

endpackage

FILE: hw/rtl/gbs_ram.sv
// Generic single write, single read RAM with registered read data.
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/gbs_iou.sv
// Pipelined overlap test of one box against the kept box per cycle.
module gbs_iou #(
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load_kept,
  input  logic                            in_v,
  input  logic [5:0]                      in_idx,
  input  logic [4*COORD_BITS-1:0]         box,
  input  logic [gbs_pkg::THR_W-1:0]       thr,
  output gbs_pkg::gbs_res_t               res,
  output logic                            busy
);
  import gbs_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = 2 * CB;
  localparam int PW = AW + 17;

  logic [CB-1:0] bl, bt, br, bb;
  logic [CB-1:0] kl_r, kt_r, kr_r, kb_r, kw_r, kh_r;
  logic [AW-1:0] area_a_r;
  logic [CB-1:0] ix0, ix1, iy0, iy1;

  logic          v1_r, v2_r, v3_r, v4_r;
  logic [5:0]    i1_r, i2_r, i3_r, i4_r;
  logic [CB-1:0] iw1_r, ih1_r, bw1_r, bh1_r;
  logic [AW-1:0] inter2_r, areab2_r, inter3_r;
  logic [AW:0]   uni3_r;
  logic [PW-1:0] prod4_r, ish4_r;
  logic          uz4_r;
  logic          res_v_r;
  logic [5:0]    res_idx_r;
  logic          res_supp_r;

  function automatic logic [CB-1:0] span(input logic [CB-1:0] lo, input logic [CB-1:0] hi);
    span = (hi > lo) ? hi - lo : '0;
  endfunction

  assign bl = box[0*CB +: CB];
  assign bt = box[1*CB +: CB];
  assign br = box[2*CB +: CB];
  assign bb = box[3*CB +: CB];

  assign ix0 = (kl_r > bl) ? kl_r : bl;
  assign ix1 = (kr_r < br) ? kr_r : br;
  assign iy0 = (kt_r > bt) ? kt_r : bt;
  assign iy1 = (kb_r < bb) ? kb_r : bb;

  always_ff @(posedge clk) begin
    if (load_kept) begin
      kl_r <= bl;
      kt_r <= bt;
      kr_r <= br;
      kb_r <= bb;
      kw_r <= span(bl, br);
      kh_r <= span(bt, bb);
    end
    area_a_r <= AW'(kw_r) * AW'(kh_r);
    iw1_r    <= span(ix0, ix1);
    ih1_r    <= span(iy0, iy1);
    bw1_r    <= span(bl, br);
    bh1_r    <= span(bt, bb);
    i1_r     <= in_idx;
    inter2_r <= AW'(iw1_r) * AW'(ih1_r);
    areab2_r <= AW'(bw1_r) * AW'(bh1_r);
    i2_r     <= i1_r;
    uni3_r   <= {1'b0, area_a_r} + {1'b0, areab2_r} - {1'b0, inter2_r};
    inter3_r <= inter2_r;
    i3_r     <= i2_r;
    prod4_r  <= PW'(thr) * PW'(uni3_r);
    ish4_r   <= PW'({inter3_r, 16'h0000});
    uz4_r    <= (uni3_r == '0);
    i4_r     <= i3_r;
    res_idx_r  <= i4_r;
    res_supp_r <= uz4_r || (ish4_r > prod4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      v1_r    <= in_v;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      res_v_r <= v4_r;
    end
  end

  assign res  = '{valid: res_v_r, idx: res_idx_r, supp: res_supp_r};
  assign busy = v1_r | v2_r | v3_r | v4_r | res_v_r;

endmodule

FILE: hw/rtl/greedy_box_suppression_top.sv
// Greedy box suppression: box store, sequencer and overlap unit.
//
// Boxes load one word per cycle (tdata: left, top, right, bottom, score; tlast marks
// the final box). After the final box the block stops taking words and runs its burst:
// for each kept box one scan over the box RAM picks the best remaining score, then a
// second scan through the overlap pipeline drops the boxes it covers too much, then the
// kept index is offered on the output. Both scans go through the single RAM read port,
// and the burst keeps at most as many boxes as were loaded. The threshold may be
// written at any time while idle.
module greedy_box_suppression_top #(
  parameter int MAX_BOXES  = gbs_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // box_left, box_top, box_right, box_bottom, box_score
  input  logic [gbs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // kept_index, zero fill
  output logic [gbs_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [gbs_pkg::THR_W-1:0]         cfg_wr_data
);
  import gbs_pkg::*;

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int CB    = COORD_BITS;
  localparam int MW    = 4 * CB + SCORE_W;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_PREP = 7'b0000010,
    S_FIND = 7'b0000100,
    S_KRD  = 7'b0001000,
    S_KLD  = 7'b0010000,
    S_SUPP = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, iss_r, iss_nxt;
  logic [MAX_BOXES-1:0] done_r, done_nxt;
  logic               rdv_r;
  logic [IDX_W-1:0]   rdidx_r;
  logic               best_v_r, best_v_nxt;
  logic [IDX_W-1:0]   best_r, best_nxt;
  logic [SCORE_W-1:0] bscore_r, bscore_nxt;
  logic               last_r, last_nxt;
  logic [THR_W-1:0]   thr_r;

  logic               we;
  logic [IDX_W-1:0]   raddr;
  logic [MW-1:0]      wdata, rdata;
  logic [SCORE_W-1:0] rscore;
  logic               issuing, scan_end, in_acc, out_acc, iou_busy;
  gbs_res_t           res;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OUT);
  assign in_acc     = in_tvalid & in_tready;
  assign out_acc    = out_tvalid & out_tready;
  assign out_tdata  = OUT_DATA_W'(KEPT_W'(best_r));
  assign out_tlast  = last_r;

  assign we    = in_acc && (cnt_r < CNT_W'(MAX_BOXES));
  assign wdata = {in_tdata[64 +: SCORE_W], in_tdata[48 +: CB], in_tdata[32 +: CB],
                  in_tdata[16 +: CB], in_tdata[0 +: CB]};
  assign issuing = (state_r == S_FIND || state_r == S_SUPP) && (iss_r < cnt_r);
  assign raddr   = (state_r == S_KRD) ? best_r : iss_r[IDX_W-1:0];
  assign rscore  = rdata[4*CB +: SCORE_W];
  assign scan_end = (iss_r == cnt_r) && !rdv_r;

  gbs_ram #(.WIDTH(MW), .DEPTH(MAX_BOXES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  gbs_iou #(.COORD_BITS(COORD_BITS)) u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_kept (state_r == S_KLD),
    .in_v      (rdv_r && state_r == S_SUPP),
    .in_idx    (6'(rdidx_r)),
    .box       (rdata[4*CB-1:0]),
    .thr       (thr_r),
    .res       (res),
    .busy      (iou_busy)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    iss_nxt    = issuing ? iss_r + 1'b1 : iss_r;
    done_nxt   = done_r;
    best_v_nxt = best_v_r;
    best_nxt   = best_r;
    bscore_nxt = bscore_r;
    last_nxt   = last_r;
    unique case (state_r)
      S_LOAD: begin
        if (we) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (in_acc && in_tlast) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        for (int i = 0; i < MAX_BOXES; i++) begin
          done_nxt[i] = (CNT_W'(i) >= cnt_r);
        end
        iss_nxt    = '0;
        best_v_nxt = 1'b0;
        state_nxt  = S_FIND;
      end
      S_FIND: begin
        if (rdv_r && !done_r[rdidx_r] && (!best_v_r || rscore > bscore_r)) begin
          best_v_nxt = 1'b1;
          best_nxt   = rdidx_r;
          bscore_nxt = rscore;
        end
        if (scan_end) begin
          done_nxt[best_r] = 1'b1;
          state_nxt        = S_KRD;
        end
      end
      S_KRD: state_nxt = S_KLD;
      S_KLD: begin
        iss_nxt   = '0;
        state_nxt = S_SUPP;
      end
      S_SUPP: begin
        if (res.valid && res.supp) begin
          done_nxt[res.idx[IDX_W-1:0]] = 1'b1;
        end
        if (scan_end && !iou_busy) begin
          last_nxt  = &done_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          iss_nxt    = '0;
          best_v_nxt = 1'b0;
          if (last_r) begin
            done_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      iss_r    <= '0;
      done_r   <= '0;
      rdv_r    <= 1'b0;
      best_v_r <= 1'b0;
      last_r   <= 1'b0;
      thr_r    <= THR_RESET;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      iss_r    <= iss_nxt;
      done_r   <= done_nxt;
      rdv_r    <= issuing;
      best_v_r <= best_v_nxt;
      last_r   <= last_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdidx_r  <= iss_r[IDX_W-1:0];
    best_r   <= best_nxt;
    bscore_r <= bscore_nxt;
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open while word offered");
  a_last_all_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> &done_r) else $error("last word with boxes left");
  a_next_find: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_tlast) |=> (state_r == S_FIND)) else $error("burst stopped early");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BOXES)) else $error("box count overflow");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for greedy box suppression: directed and random box sets.
`timescale 1ns / 1ps

module tb_top;
  import gbs_pkg::*;

  localparam int          NBOX      = 64;
  localparam int          MAX_GAP   = 13;
  localparam int unsigned CYC_LIMIT = 2000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [THR_W-1:0]      cfg_wr_data;

  typedef struct packed {
    logic [KEPT_W-1:0] idx;
    logic              last;
  } kept_t;

  // model state
  logic [THR_W-1:0]   thr_m;
  logic [15:0]        box_l [NBOX];
  logic [15:0]        box_t [NBOX];
  logic [15:0]        box_r [NBOX];
  logic [15:0]        box_b [NBOX];
  logic [SCORE_W-1:0] box_s [NBOX];
  int                 nboxes;
  kept_t              kept_q [$];

  int unsigned cycles;
  int          errors;
  int          boxes_sent;
  int          sets_done;
  int          words_seen;
  bit          no_idle;
  int          out_stall;

  greedy_box_suppression_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic logic [63:0] span(logic [63:0] lo, logic [63:0] hi);
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  function automatic bit covers_too_much(int a, int b);
    logic [63:0] iw, ih, inter, area_a, area_b, uni;
    iw = span((box_l[a] > box_l[b]) ? box_l[a] : box_l[b],
              (box_r[a] < box_r[b]) ? box_r[a] : box_r[b]);
    ih = span((box_t[a] > box_t[b]) ? box_t[a] : box_t[b],
              (box_b[a] < box_b[b]) ? box_b[a] : box_b[b]);
    inter  = iw * ih;
    area_a = span(box_l[a], box_r[a]) * span(box_t[a], box_b[a]);
    area_b = span(box_l[b], box_r[b]) * span(box_t[b], box_b[b]);
    uni    = area_a + area_b - inter;
    if (uni == 64'd0) return 1'b1;
    return (inter << 16) > (64'(thr_m) * uni);
  endfunction

  function automatic void run_suppression();
    int  rank [NBOX];
    bit  dropped [NBOX];
    int  i, j, first;
    kept_t k;
    for (i = 0; i < nboxes; i++) begin
      j = i;
      while (j > 0 && box_s[rank[j-1]] < box_s[i]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
      dropped[i] = 1'b0;
    end
    first = kept_q.size();
    for (i = 0; i < nboxes; i++) begin
      if (!dropped[rank[i]]) begin
        k.idx  = KEPT_W'(rank[i]);
        k.last = 1'b0;
        kept_q.insert(kept_q.size(), k);
        for (j = i + 1; j < nboxes; j++)
          if (!dropped[rank[j]] && covers_too_much(rank[i], rank[j]))
            dropped[rank[j]] = 1'b1;
      end
    end
    if (kept_q.size() > first) kept_q[kept_q.size()-1].last = 1'b1;
    nboxes = 0;
  endfunction

  function automatic void take_box(logic [15:0] l, t, r, b, s, logic last);
    if (nboxes < NBOX) begin
      box_l[nboxes] = l;
      box_t[nboxes] = t;
      box_r[nboxes] = r;
      box_b[nboxes] = b;
      box_s[nboxes] = s;
      nboxes++;
    end
    if (last) begin
      run_suppression();
      sets_done++;
    end
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(MAX_GAP, 0);
  endfunction

  task automatic send_box(logic [15:0] l, t, r, b, s, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {s, b, r, t, l};
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    take_box(l, t, r, b, s, last);
    boxes_sent++;
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (kept_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_thr(logic [THR_W-1:0] v);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    thr_m       = v;
  endtask

  task automatic send_rand_box(logic last, int spread);
    logic [15:0] l, t, w, h;
    l = 16'($urandom_range(spread, 0));
    t = 16'($urandom_range(spread, 0));
    w = 16'($urandom_range(spread / 2 + 1, 0));
    h = 16'($urandom_range(spread / 2 + 1, 0));
    if ($urandom_range(15, 0) == 0)
      send_box(l + w, t, l, t + h, 16'($urandom_range(7, 0)), last);
    else
      send_box(l, t, l + w, t + h, 16'($urandom_range(7, 0) * 9000), last);
  endtask

  // extremes, ties, zero area, inverted boxes, single box
  task automatic test_directed();
    send_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_box(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
    send_box(16'd10, 16'd10, 16'd10, 16'd10, 16'h7FFF, 1'b0);
    send_box(16'd10, 16'd10, 16'd10, 16'd10, 16'h7FFF, 1'b0);
    send_box(16'd200, 16'd200, 16'd100, 16'd300, 16'h1234, 1'b0);
    send_box(16'd100, 16'd300, 16'd200, 16'd200, 16'h1234, 1'b0);
    send_box(16'h5555, 16'hAAAA, 16'h5556, 16'hAAAB, 16'h5555, 1'b0);
    send_box(16'd0, 16'd0, 16'd100, 16'd100, 16'hAAAA, 1'b0);
    send_box(16'd50, 16'd0, 16'd150, 16'd100, 16'h0001, 1'b1);
    go_idle();
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    go_idle();
  endtask

  task automatic test_thresholds();
    logic [THR_W-1:0] thr_set [4];
    int i, k, n;
    thr_set = '{16'd0, 16'hFFFF, 16'd32768, THR_RESET};
    for (i = 0; i < 4; i++) begin
      write_thr(thr_set[i]);
      n = $urandom_range(6, 3);
      for (k = 0; k < n; k++) send_rand_box(k == n - 1, 400);
      go_idle();
    end
  endtask

  // full store, then boxes past the store; the final one only starts the burst
  task automatic test_store_full();
    int k;
    for (k = 0; k < NBOX + 2; k++) send_rand_box(k == NBOX + 1, 3000);
    go_idle();
  endtask

  task automatic test_random();
    int k, n, spread;
    while (boxes_sent < 150) begin
      no_idle = ($urandom_range(4, 0) == 0);
      if ($urandom_range(2, 0) == 0) write_thr(16'($urandom()));
      n      = $urandom_range(8, 1);
      spread = ($urandom_range(3, 0) == 0) ? 65535 : 500;
      for (k = 0; k < n; k++) send_rand_box(k == n - 1, spread);
      go_idle();
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall  <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    kept_t exp_k;
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("** greedy_box_suppression_top: FAILED **");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      words_seen <= words_seen + 1;
      out_stall  <= draw_gap();
      if (kept_q.size() == 0) begin
        $error("unexpected word: kept_index %0d", out_tdata[KEPT_W-1:0]);
        errors++;
      end else begin
        exp_k = kept_q.pop_front();
        if (out_tdata[KEPT_W-1:0] !== exp_k.idx) begin
          $error("kept_index: expected %0d, got %0d", exp_k.idx, out_tdata[KEPT_W-1:0]);
          errors++;
        end
        if (out_tlast !== exp_k.last) begin
          $error("last_kept: expected %0d, got %0d", exp_k.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    cycles      = 0;
    errors      = 0;
    boxes_sent  = 0;
    sets_done   = 0;
    words_seen  = 0;
    no_idle     = 1'b0;
    out_stall   = 0;
    nboxes      = 0;
    thr_m       = THR_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_thresholds();
    test_store_full();
    test_random();
    go_idle();
    if (kept_q.size() != 0) begin
      $error("%0d kept words never arrived", kept_q.size());
      errors++;
    end

    $display("Covered %0d boxes in %0d sets, %0d kept words checked,", boxes_sent,
             sets_done, words_seen);
    $display("including full-store overflow, threshold extremes and zero-area boxes.");
    if (errors == 0) begin
      $display("** greedy_box_suppression_top: PASSED **");
    end else begin
      $display("** greedy_box_suppression_top: FAILED **");
    end
    $finish;
  end

endmodule
